// ----- hdl/octahedral_normal_decode_core_macros.svh -----
// assertion helpers for the octahedral normal decoder
`ifndef OCTAHEDRAL_NORMAL_DECODE_CORE_MACROS_SVH
`define OCTAHEDRAL_NORMAL_DECODE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// a implies b in the same cycle
`define OND_ASSERT_NOW(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// a implies b later, after the delay given by n
`define OND_ASSERT_AFTER(lbl, a, n, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> ##n (b)) \
    else $error("assertion failed");
`else
`define OND_ASSERT_NOW(lbl, a, b)
`define OND_ASSERT_AFTER(lbl, a, n, b)
`endif
`endif

// ----- hdl/ond_pkg.sv -----
`default_nettype none
package ond_pkg;
  // working fraction bits of the internal vector
  localparam int WORK_FRAC = 30;
  // floor(1e-8 * 2^60): squared length limit for normalizing
  localparam logic [63:0] LEN2_THRESHOLD = 64'd11529215046;
  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = 2;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;
endpackage
`default_nettype wire

// ----- hdl/ond_front.sv -----
`default_nettype none
module ond_front import ond_pkg::*; #(
  parameter int CODE_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 signed_codes,
  input  logic [CODE_BITS-1:0] code_x,
  input  logic [CODE_BITS-1:0] code_y,
  output logic                 out_valid,
  output vec_t                 out_vec
);
  localparam int CB = CODE_BITS;
  localparam int VB = 2 * CB + 1;
  localparam int RB = CB + 4;
  localparam logic [63:0] ONE  = 64'd1 << WORK_FRAC;
  localparam logic [63:0] MAXU = (64'd1 << CB) - 64'd1;
  localparam logic [63:0] MAXS = (64'd1 << (CB - 1)) - 64'd1;
  localparam logic [63:0] Q0U = ONE / MAXU;
  localparam logic [63:0] R0U = ONE % MAXU;
  localparam logic [63:0] Q0S = ONE / MAXS;
  localparam logic [63:0] R0S = ONE % MAXS;
  localparam logic [63:0] RCU = (64'd1 << VB) / MAXU;
  localparam logic [63:0] RCS = (64'd1 << VB) / MAXS;

  logic [CB-1:0] code [2];
  assign code[0] = code_x;
  assign code[1] = code_y;

  // stage registers
  logic v1, v2, v3, v4, v5, v6;
  logic s1, s2;
  logic [CB-1:0] mag1 [2];
  logic          neg1 [2], neg2 [2], neg3 [2], neg4 [2];
  logic [30:0]   qa2 [2], qa3 [2], qa4 [2];
  logic [VB-1:0] p2 [2], p3 [2], p4 [2];
  logic [RB-1:0] e3 [2];
  logic signed [31:0] c5 [2];
  logic [CB-1:0] den3, den4;
  logic [30:0]   q0sel;
  logic [CB-1:0] r0sel, hsel, densel3;
  logic [RB-1:0] rsel, rsel3;

  // constant selection by code mode
  always_comb begin
    q0sel   = s1 ? Q0S[30:0] : Q0U[30:0];
    r0sel   = s1 ? R0S[CB-1:0] : R0U[CB-1:0];
    hsel    = s1 ? MAXS[CB:1] : MAXU[CB:1];
    rsel    = s2 ? RCS[RB-1:0] : RCU[RB-1:0];
    densel3 = s2 ? MAXS[CB-1:0] : MAXU[CB-1:0];
  end

  // control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6} <= '0;
    end else begin
      {v1, v2, v3, v4, v5, v6} <= {in_valid, v1, v2, v3, v4, v5};
    end
  end

  // reciprocal and divisor follow the item down the stages
  always_ff @(posedge clk) begin
    s1 <= signed_codes;
    s2 <= s1;
    den3 <= densel3;
    den4 <= den3;
    rsel3 <= rsel;
  end

  for (genvar i = 0; i < 2; i++) begin : g_lane
    logic signed [CB+1:0] un_num;
    logic [CB+1:0]        un_abs;
    logic [CB-1:0]        mag0;
    logic                 neg0;
    logic [CB+RB-1:0]     edp;
    logic [VB+RB-1:0]     prod;
    logic [VB-1:0]        rem;
    logic [30:0]          q;

    // code to magnitude and sign
    always_comb begin
      un_num = $signed({1'b0, code[i], 1'b0}) - $signed({2'b00, MAXU[CB-1:0]});
      un_abs = un_num[CB+1] ? 2'(0) - un_num : un_num;
      if (signed_codes) begin
        neg0 = code[i][CB-1];
        if (code[i] == {1'b1, {(CB-1){1'b0}}}) mag0 = MAXS[CB-1:0];
        else if (code[i][CB-1]) mag0 = ~code[i] + 1'b1;
        else mag0 = code[i];
      end else begin
        neg0 = un_num[CB+1];
        mag0 = un_abs[CB-1:0];
      end
    end

    // reciprocal estimate of the remainder quotient, then one correction step
    always_comb begin
      prod = {{RB{1'b0}}, p3[i]} * {{VB{1'b0}}, rsel3};
      edp  = {{CB{1'b0}}, e3[i]} * {{RB{1'b0}}, den4};
      rem  = p4[i] - edp[VB-1:0];
      q    = qa4[i] + 31'(e3[i]) + 31'(rem >= VB'(den4));
    end

    always_ff @(posedge clk) begin
      mag1[i] <= mag0;
      neg1[i] <= neg0;
      qa2[i]  <= {{(31-CB){1'b0}}, mag1[i]} * q0sel;
      p2[i]   <= VB'({{(CB+1){1'b0}}, mag1[i]} * {{(CB+1){1'b0}}, r0sel}) + VB'(hsel);
      neg2[i] <= neg1[i];
      qa3[i]  <= qa2[i];
      p3[i]   <= p2[i];
      neg3[i] <= neg2[i];
      e3[i]   <= RB'(prod >> VB);
      qa4[i]  <= qa3[i];
      p4[i]   <= p3[i];
      neg4[i] <= neg3[i];
      c5[i]   <= neg4[i] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end
  end

  // octahedral unfold
  logic signed [31:0] ax, ay, zf, tf;
  always_comb begin
    ax = c5[0][31] ? -c5[0] : c5[0];
    ay = c5[1][31] ? -c5[1] : c5[1];
    zf = $signed(ONE[31:0]) - ax - ay;
    tf = zf[31] ? -zf : 32'sd0;
  end

  always_ff @(posedge clk) begin
    out_vec.x <= c5[0][31] ? c5[0] + tf : c5[0] - tf;
    out_vec.y <= c5[1][31] ? c5[1] + tf : c5[1] - tf;
    out_vec.z <= zf;
  end
  assign out_valid = v6;
endmodule
`default_nettype wire

// ----- hdl/ond_queue.sv -----
`default_nettype none
module ond_queue import ond_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  vec_t      push_vec,
  output logic      pop_valid,
  output vec_t      pop_vec,
  output q_status_t status
);
  vec_t                 mem [QDEPTH];
  logic [QPTR_BITS-1:0] wptr, rptr;
  logic [QPTR_BITS:0]   count;
  logic                 pop;

  // the back end drains one item every cycle while the queue is not empty
  assign pop          = count != '0;
  assign pop_valid    = pop;
  assign pop_vec      = mem[rptr];
  assign status.full  = count == (QPTR_BITS+1)'(QDEPTH);
  assign status.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_vec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// ----- hdl/ond_back.sv -----
`default_nettype none
module ond_back import ond_pkg::*; #(
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  vec_t               in_vec,
  output logic               done,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z
);
  localparam int F  = OUT_FRAC_BITS;
  localparam int DS = F + 2;
  localparam int SQ = 32;
  localparam int SH = WORK_FRAC - F;
  localparam logic [33:0] RND = (SH > 0) ? (34'd1 << (SH - 1)) : 34'd0;
  localparam logic [33:0] PLIM = (F >= 15) ? 34'd32767 : (34'd1 << F) - 34'd1;
  localparam logic [33:0] NLIM = (F >= 15) ? 34'd32768 : (34'd1 << F);

  typedef struct packed {
    logic             valid;
    logic             norm;
    logic [2:0]       neg;
    logic [2:0][30:0] mag;
  } carry_t;

  // magnitudes and squares
  carry_t     c1, c2, cs [SQ+1], cd [DS+1];
  logic [61:0] sq [3];
  logic [63:0] len2;
  logic signed [31:0] comp [3];
  assign comp[0] = in_vec.x;
  assign comp[1] = in_vec.y;
  assign comp[2] = in_vec.z;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.valid <= 1'b0;
      c2.valid <= 1'b0;
    end else begin
      c1.valid <= in_valid;
      c2.valid <= c1.valid;
    end
    c1.norm <= 1'b0;
    for (int i = 0; i < 3; i++) begin
      c1.neg[i] <= comp[i][31];
      c1.mag[i] <= comp[i][31] ? 31'(-comp[i]) : comp[i][30:0];
      sq[i]     <= {31'd0, c1.mag[i]} * {31'd0, c1.mag[i]};
    end
    c2.norm <= c1.norm;
    c2.neg  <= c1.neg;
    c2.mag  <= c1.mag;
  end

  // squared length
  always_comb begin
    len2 = {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};
  end

  logic [63:0] sv [SQ+1];
  logic [63:0] sr [SQ+1];

  always_ff @(posedge clk) begin
    if (rst) cs[0].valid <= 1'b0;
    else cs[0].valid <= c2.valid;
    cs[0].norm <= len2 > LEN2_THRESHOLD;
    cs[0].neg  <= c2.neg;
    cs[0].mag  <= c2.mag;
    sv[0]      <= len2;
    sr[0]      <= '0;
  end

  // square root, one result bit per stage
  for (genvar s = 0; s < SQ; s++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * s);
    logic [63:0] trial;
    logic        take;
    always_comb begin
      trial = sr[s] + BIT;
      take  = sv[s] >= trial;
    end
    always_ff @(posedge clk) begin
      if (rst) cs[s+1].valid <= 1'b0;
      else cs[s+1].valid <= cs[s].valid;
      cs[s+1].norm <= cs[s].norm;
      cs[s+1].neg  <= cs[s].neg;
      cs[s+1].mag  <= cs[s].mag;
      sv[s+1]      <= take ? sv[s] - trial : sv[s];
      sr[s+1]      <= take ? (sr[s] >> 1) + BIT : sr[s] >> 1;
    end
  end

  // restoring divide of each magnitude by the length
  logic [31:0]   lenp [DS+1];
  logic [32:0]   rem [DS+1][3];
  logic [DS-1:0] quo [DS+1][3];

  always_comb begin
    cd[0]   = cs[SQ];
    lenp[0] = sr[SQ][31:0];
    for (int i = 0; i < 3; i++) begin
      rem[0][i] = {2'b00, cs[SQ].mag[i]};
      quo[0][i] = '0;
    end
  end

  for (genvar d = 0; d < DS; d++) begin : g_div
    logic [32:0] rin [3];
    logic        ge [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rin[i] = (d == 0) ? rem[d][i] : (rem[d][i] << 1);
        ge[i]  = rin[i] >= {1'b0, lenp[d]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) cd[d+1].valid <= 1'b0;
      else cd[d+1].valid <= cd[d].valid;
      cd[d+1].norm <= cd[d].norm;
      cd[d+1].neg  <= cd[d].neg;
      cd[d+1].mag  <= cd[d].mag;
      lenp[d+1]    <= lenp[d];
      for (int i = 0; i < 3; i++) begin
        rem[d+1][i] <= ge[i] ? rin[i] - {1'b0, lenp[d]} : rin[i];
        quo[d+1][i] <= {quo[d][i][DS-2:0], ge[i]};
      end
    end
  end

  // rounding, saturation and sign
  logic [33:0]        val [3];
  logic [33:0]        lim [3];
  logic signed [15:0] res [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cd[DS].norm) val[i] = (34'(quo[DS][i]) + 34'd1) >> 1;
      else val[i] = (34'(cd[DS].mag[i]) + RND) >> SH;
      if (cd[DS].neg[i]) begin
        lim[i] = (val[i] > NLIM) ? NLIM : val[i];
        res[i] = 16'(34'd0 - lim[i]);
      end else begin
        lim[i] = (val[i] > PLIM) ? PLIM : val[i];
        res[i] = lim[i][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= cd[DS].valid;
  end
  always_ff @(posedge clk) begin
    normal_x <= res[0];
    normal_y <= res[1];
    normal_z <= res[2];
  end
endmodule
`default_nettype wire

// ----- hdl/octahedral_normal_decode_core.sv -----
`default_nettype none
// octahedral normal decoder
// command channel: an item (code_x, code_y) is taken at a clock edge with
// start high and busy low. one result (normal_x, normal_y, normal_z, signed,
// OUT_FRAC_BITS fraction bits) appears for one cycle with done high.
// configuration: cfg_write with cfg_data sets the code mode (0 unorm,
// 1 snorm); write it only while no item is in flight.
// throughput: one item per cycle, every cycle; busy stays low because the
// back end drains the queue every cycle.
// path: an accepted item passes six front stages for code decode and
// unfold, one queue slot, three stages for squares and length, 32 square
// root stages (one root bit each), OUT_FRAC_BITS + 2 restoring divide
// stages (one quotient bit each) and the output register that raises done.
// the receiver cannot stall, results are never held.
// reset clears all valid flags, empties the queue and sets unorm mode.
module octahedral_normal_decode_core import ond_pkg::*; #(
  parameter int CODE_BITS     = 10,
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [CODE_BITS-1:0] code_x,
  input  logic [CODE_BITS-1:0] code_y,
  input  logic                 cfg_write,
  input  logic                 cfg_data,
  output logic                 done,
  output logic signed [15:0]   normal_x,
  output logic signed [15:0]   normal_y,
  output logic signed [15:0]   normal_z
);
`include "octahedral_normal_decode_core_macros.svh"

  localparam int LATENCY = 45 + OUT_FRAC_BITS;

  logic      signed_codes;
  logic      accept, f_valid, q_valid;
  vec_t      f_vec, q_vec;
  q_status_t q_stat;

  // code mode register
  always_ff @(posedge clk) begin
    if (rst) signed_codes <= 1'b0;
    else if (cfg_write) signed_codes <= cfg_data;
  end

  assign busy   = q_stat.full;
  assign accept = start && !busy;

  ond_front #(.CODE_BITS(CODE_BITS)) u_front (
    .clk, .rst, .in_valid(accept), .signed_codes, .code_x, .code_y,
    .out_valid(f_valid), .out_vec(f_vec)
  );

  ond_queue u_queue (
    .clk, .rst, .push(f_valid), .push_vec(f_vec),
    .pop_valid(q_valid), .pop_vec(q_vec), .status(q_stat)
  );

  ond_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
    .clk, .rst, .in_valid(q_valid), .in_vec(q_vec),
    .done, .normal_x, .normal_y, .normal_z
  );

  // every accepted item comes out after the fixed pipeline latency
  `OND_ASSERT_AFTER(a_latency, accept, LATENCY, done)
  // the queue never backs up since it drains every cycle
  `OND_ASSERT_NOW(a_queue_drains, q_stat.empty, !q_valid)
  `OND_ASSERT_NOW(a_never_full, 1'b1, !q_stat.full)
endmodule
`default_nettype wire

// ----- dv/octahedral_normal_decode_checker.sv -----
`default_nettype none
module octahedral_normal_decode_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [9:0]         code_x,
  input  logic [9:0]         code_y,
  input  logic               cfg_write,
  input  logic               cfg_data,
  input  logic               done,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 30;
  localparam int OUT_FRAC = 15;
  localparam longint unsigned SQ_LIMIT = 64'd11529215046;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } normal_t;

  normal_t normals_due[$];
  logic snorm_mode;
  int mismatches;

  // nearest rounding, ties away from zero
  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // code to q1.30 coordinate
  function automatic longint code_to_coord(logic [9:0] code, logic snorm);
    longint v;
    if (snorm) begin
      v = longint'($signed(code));
      if (v < -511) v = -511;
      return round_div(v <<< FRAC, 511);
    end
    v = 2 * longint'(code) - 1023;
    return round_div(v <<< FRAC, 1023);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clamp_q15(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] scale_component(longint c, longint unsigned len,
                                                         bit norm);
    if (norm) return clamp_q15(round_div(c * (64'sd1 <<< OUT_FRAC), len));
    return clamp_q15(round_div(c, 64'd1 << (FRAC - OUT_FRAC)));
  endfunction

  function automatic normal_t decode_normal(logic [9:0] cx, logic [9:0] cy, logic snorm);
    longint x, y, z, t;
    longint unsigned ux, uy, uz, len2, len;
    bit norm;
    normal_t r;
    x = code_to_coord(cx, snorm);
    y = code_to_coord(cy, snorm);
    z = (64'sd1 <<< FRAC) - (x < 0 ? -x : x) - (y < 0 ? -y : y);
    t = (z < 0) ? -z : 0;
    x = (x >= 0) ? x - t : x + t;
    y = (y >= 0) ? y - t : y + t;
    ux = (x < 0) ? -x : x;
    uy = (y < 0) ? -y : y;
    uz = (z < 0) ? -z : z;
    len2 = ux * ux + uy * uy + uz * uz;
    norm = len2 > SQ_LIMIT;
    len = norm ? int_sqrt(len2) : 1;
    r.x = scale_component(x, len, norm);
    r.y = scale_component(y, len, norm);
    r.z = scale_component(z, len, norm);
    return r;
  endfunction

  // track mode, predict accepted items, compare results
  always @(posedge clk) begin
    normal_t exp_n;
    normal_t got;
    if (rst) begin
      snorm_mode <= 1'b0;
      normals_due.delete();
      fail_count <= 0;
      mismatches = 0;
      pending <= 0;
    end else begin
      if (cfg_write) snorm_mode <= cfg_data;
      if (start && !busy)
        normals_due.insert(normals_due.size(),
                           decode_normal(code_x, code_y, snorm_mode));
      if (done) begin
        got = '{normal_x, normal_y, normal_z};
        if (normals_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected normal x=%0d y=%0d z=%0d",
                     normal_x, normal_y, normal_z);
        end else begin
          exp_n = normals_due.pop_front();
          if (got !== exp_n) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: normal mismatch exp (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                       exp_n.x, exp_n.y, exp_n.z, normal_x, normal_y, normal_z);
          end
        end
      end
      fail_count <= mismatches;
      pending <= normals_due.size();
    end
  end
endmodule
`default_nettype wire

// ----- dv/tb_octahedral_normal_decode_core.sv -----
`default_nettype none
module tb_octahedral_normal_decode_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_UNORM = 1'b0;
  localparam logic MODE_SNORM = 1'b1;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [9:0] code_x = '0;
  logic [9:0] code_y = '0;
  logic cfg_write = 1'b0;
  logic cfg_data = 1'b0;
  logic done;
  logic signed [15:0] normal_x, normal_y, normal_z;
  int fail_count, pending;
  int quiet_cycles = 0;
  bit burst;

  always #5 clk = ~clk;

  octahedral_normal_decode_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .code_x(code_x), .code_y(code_y),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .done(done), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
  );

  octahedral_normal_decode_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .code_x(code_x), .code_y(code_y),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .done(done), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .fail_count(fail_count), .pending(pending)
  );

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // present one item, hold until taken, then optional gap
  task automatic send_codes(logic [9:0] cx, logic [9:0] cy);
    int gap;
    start <= 1'b1;
    code_x <= cx;
    code_y <= cy;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    gap = burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // mode change only with nothing in flight
  task automatic set_mode(logic m);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic directed_items();
    logic [9:0] pts [6];
    pts = '{10'd0, 10'd1023, 10'd511, 10'd512, 10'd513, 10'd1};
    for (int i = 0; i < 6; i++) send_codes(pts[i], pts[(i + 1) % 6]);
    send_codes(10'd0, 10'd0);
    send_codes(10'd1023, 10'd1023);
    send_codes(10'd512, 10'd0);
    send_codes(10'd256, 10'd768);
  endtask

  task automatic random_items(int n);
    logic [9:0] cx, cy;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      cx = 10'($urandom);
      cy = 10'($urandom);
      // bias toward octant edges and the fold seam
      if ($urandom_range(0, 5) == 0) cx = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
      if ($urandom_range(0, 7) == 0) cy = 10'd1023 - cx;
      send_codes(cx, cy);
    end
    burst = 0;
  endtask

  initial begin
    burst = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_items();
    set_mode(MODE_SNORM);
    directed_items();
    random_items(300);
    set_mode(MODE_UNORM);
    random_items(300);
    set_mode(MODE_SNORM);
    random_items(250);
    set_mode(MODE_UNORM);
    random_items(250);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+hdl
hdl/ond_pkg.sv
hdl/ond_front.sv
hdl/ond_queue.sv
hdl/ond_back.sv
hdl/octahedral_normal_decode_core.sv
dv/octahedral_normal_decode_checker.sv
dv/tb_octahedral_normal_decode_core.sv
